// ----- rtl/sid_pkg.sv -----
package sid_pkg;

    localparam int SID_DATA_WIDTH = 32;

    typedef struct packed {
        logic valid;
        logic q_neg;
        logic div_zero;
    } sid_ctl_t;

endpackage

// ----- rtl/sid_prep.sv -----
module sid_prep #(
    parameter int DATA_WIDTH = sid_pkg::SID_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] numerator,
    input  logic [DATA_WIDTH-1:0] denominator,
    output sid_pkg::sid_ctl_t     ctl_out,
    output logic [DATA_WIDTH-1:0] dq_out,
    output logic [DATA_WIDTH-1:0] den_out
);

    logic                  n_neg;
    logic                  d_neg;
    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH-1:0] d_mag;
    sid_pkg::sid_ctl_t     ctl_next;
    sid_pkg::sid_ctl_t     ctl_reg;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    // magnitudes as unsigned, most negative value maps to 2^(w-1)
    always_comb begin
        n_neg = numerator[DATA_WIDTH-1];
        d_neg = denominator[DATA_WIDTH-1];
        n_mag = n_neg ? (~numerator + 1'b1) : numerator;
        d_mag = d_neg ? (~denominator + 1'b1) : denominator;
        ctl_next.valid    = in_valid;
        ctl_next.q_neg    = n_neg ^ d_neg;
        ctl_next.div_zero = (denominator == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dq_reg  <= n_mag;
            den_reg <= d_mag;
        end
    end

    assign ctl_out = ctl_reg;
    assign dq_out  = dq_reg;
    assign den_out = den_reg;

endmodule

// ----- rtl/sid_stage.sv -----
module sid_stage #(
    parameter int DATA_WIDTH = sid_pkg::SID_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  sid_pkg::sid_ctl_t     ctl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] dq_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    output sid_pkg::sid_ctl_t     ctl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] dq_out,
    output logic [DATA_WIDTH-1:0] den_out
);

    logic [DATA_WIDTH-1:0] trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  q_bit;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] dq_next;
    sid_pkg::sid_ctl_t     ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    // one restoring step: remainder stays below divisor, so the shift fits
    always_comb begin
        trial    = {rem_in[DATA_WIDTH-2:0], dq_in[DATA_WIDTH-1]};
        diff     = {1'b0, trial} - {1'b0, den_in};
        q_bit    = ~diff[DATA_WIDTH];
        rem_next = q_bit ? diff[DATA_WIDTH-1:0] : trial;
        dq_next  = {dq_in[DATA_WIDTH-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            den_reg <= den_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;
    assign den_out = den_reg;

endmodule

// ----- rtl/sid_fix.sv -----
module sid_fix #(
    parameter int DATA_WIDTH = sid_pkg::SID_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  sid_pkg::sid_ctl_t     ctl_in,
    input  logic [DATA_WIDTH-1:0] q_mag,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] quotient
);

    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic [DATA_WIDTH-1:0] quotient_next;
    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] quotient_reg;

    // saturate on zero divisor and on positive overflow
    always_comb begin
        if (ctl_in.div_zero) begin
            quotient_next = POS_MAX;
        end else if (ctl_in.q_neg) begin
            quotient_next = ~q_mag + 1'b1;
        end else if (q_mag[DATA_WIDTH-1]) begin
            quotient_next = POS_MAX;
        end else begin
            quotient_next = q_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            quotient_reg <= quotient_next;
        end
    end

    assign out_valid = valid_reg;
    assign quotient  = quotient_reg;

endmodule

// ----- rtl/signed_int32_divider.sv -----
// Pipelined signed divider. Each beat on the slave side carries a two's complement dividend
// and divisor; each beat on the master side carries the quotient truncated toward zero. A zero
// divisor, and the most negative dividend over minus one, give the largest positive value.
// One beat is accepted every cycle while the output is taken; a result passes through an
// operand stage, one restoring subtract stage per quotient bit and a sign stage, each
// registered. A stall on the master side holds the whole pipeline in place.
module signed_int32_divider #(
    parameter  int DATA_WIDTH = sid_pkg::SID_DATA_WIDTH,
    localparam int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // numerator, denominator
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // quotient
);

    logic                  advance;
    logic                  out_valid;
    logic [DATA_WIDTH-1:0] quotient;

    sid_pkg::sid_ctl_t     ctl_pipe [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_pipe [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dq_pipe  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_pipe [0:DATA_WIDTH];

    assign advance     = ~out_valid | m_tready;
    assign s_tready    = advance;
    assign rem_pipe[0] = '0;

    sid_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (s_tvalid),
        .numerator   (s_tdata[DATA_WIDTH-1:0]),
        .denominator (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .ctl_out     (ctl_pipe[0]),
        .dq_out      (dq_pipe[0]),
        .den_out     (den_pipe[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
        sid_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .ctl_in  (ctl_pipe[i]),
            .rem_in  (rem_pipe[i]),
            .dq_in   (dq_pipe[i]),
            .den_in  (den_pipe[i]),
            .ctl_out (ctl_pipe[i+1]),
            .rem_out (rem_pipe[i+1]),
            .dq_out  (dq_pipe[i+1]),
            .den_out (den_pipe[i+1])
        );
    end

    sid_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .ctl_in    (ctl_pipe[DATA_WIDTH]),
        .q_mag     (dq_pipe[DATA_WIDTH]),
        .out_valid (out_valid),
        .quotient  (quotient)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'(quotient);

endmodule

// ----- sim/sid_quotient_checker.sv -----
`timescale 1ns / 100ps

module sid_quotient_checker #(
    parameter  int DW        = sid_pkg::SID_DATA_WIDTH,
    localparam int S_TDATA_W = ((2 * DW + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DW + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // numerator, denominator
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // quotient
    output int                   fail_count,
    output int                   pending
);

    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW - 1){1'b1}}};

    typedef struct {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [DW-1:0] quot;
    } division_t;

    division_t expected_quotients[$];

    function automatic logic [DW-1:0] predict_quotient(input logic [DW-1:0] num,
                                                       input logic [DW-1:0] den);
        logic [DW-1:0] mag_n;
        logic [DW-1:0] mag_d;
        logic [DW-1:0] q;
        if (den == '0) begin
            return POS_MAX;
        end
        mag_n = num[DW-1] ? -num : num;
        mag_d = den[DW-1] ? -den : den;
        q     = mag_n / mag_d;
        if (num[DW-1] == den[DW-1]) begin
            return (q > POS_MAX) ? POS_MAX : q;
        end
        return -q;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        division_t item;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_quotients.size() == 0) begin
                    report_mismatch($sformatf("unexpected quotient beat %0d",
                                              $signed(m_tdata[DW-1:0])));
                end else begin
                    item = expected_quotients.pop_front();
                    if (m_tdata !== M_TDATA_W'(item.quot)) begin
                        report_mismatch($sformatf("quotient of %0d / %0d: got %0d, want %0d",
                                                  $signed(item.num), $signed(item.den),
                                                  $signed(m_tdata[DW-1:0]),
                                                  $signed(item.quot)));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item.num  = s_tdata[DW-1:0];
                item.den  = s_tdata[2*DW-1:DW];
                item.quot = predict_quotient(item.num, item.den);
                expected_quotients.push_back(item);
            end
        end
        pending = expected_quotients.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int DW        = sid_pkg::SID_DATA_WIDTH;
    localparam int S_TDATA_W = ((2 * DW + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DW + 7) / 8) * 8;
    localparam int RANDOM_BEATS = 500;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW - 1){1'b0}}};
    localparam logic [DW-1:0] MINUS_1 = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // numerator, denominator
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // quotient

    int fail_count;
    int pending;
    int cycle_count;
    bit no_idle;

    signed_int32_divider #(
        .DATA_WIDTH(DW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    sid_quotient_checker #(
        .DW(DW)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // random backpressure on the quotient side
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= no_idle || ($urandom_range(0, 99) >= 31);
        end
    end

    function automatic logic [DW-1:0] random_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4, 5: begin
                v = $urandom_range(0, 128);
                v = v - 64;
            end
            6: begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = MINUS_1;
                    3:       v = NEG_MIN;
                    4:       v = POS_MAX;
                    default: v = NEG_MIN + 1;
                endcase
            end
            default: begin
                v = $urandom() >> $urandom_range(0, DW - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(input logic [DW-1:0] num, input logic [DW-1:0] den);
        while (!no_idle && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({den, num});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        no_idle  = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // zero divisor, overflow, most negative divisor and plain signs
        send_beat(0, 0);
        send_beat(5, 0);
        send_beat(-5, 0);
        send_beat(NEG_MIN, 0);
        send_beat(POS_MAX, 0);
        send_beat(NEG_MIN, MINUS_1);
        send_beat(NEG_MIN, 1);
        send_beat(NEG_MIN, NEG_MIN);
        send_beat(5, NEG_MIN);
        send_beat(-5, NEG_MIN);
        send_beat(POS_MAX, NEG_MIN);
        send_beat(POS_MAX, 1);
        send_beat(POS_MAX, MINUS_1);
        send_beat(POS_MAX, POS_MAX);
        send_beat(NEG_MIN, POS_MAX);
        send_beat(7, 2);
        send_beat(-7, 2);
        send_beat(7, -2);
        send_beat(-7, -2);
        send_beat(0, MINUS_1);
        send_beat(1, POS_MAX);
        send_beat(MINUS_1, 1);
        send_beat(100, 7);
        send_beat(NEG_MIN, 2);
        hold_until_drained();

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            no_idle = (i >= 200 && i < 320);
            if (i == 400) begin
                hold_until_drained();
            end
            send_beat(random_operand(), random_operand());
        end
        no_idle = 1'b0;
        hold_until_drained();
        repeat (DW + 8) @(negedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
